@@ hw/rtl/ptua_pkg.sv @@
// ----------------------------------------------------------------------------
// ptua_pkg
// Shared widths, register indexes, reset values and stage structs for the
// palettized texture unswizzle address pipeline.
// ----------------------------------------------------------------------------
package ptua_pkg;

  localparam int COORD_W     = 10;  // pixel_x / pixel_y
  localparam int BYTE_ADDR_W = 20;  // byte_address
  localparam int CFG_W       = 4;   // widest configuration register
  localparam int CFG_IDX_W   = 2;
  localparam int LOG_W       = 4;   // size exponent registers
  localparam int SUM_LOG_W   = 5;   // width_log2 + height_log2
  localparam int PAGE_LOG2   = 7;   // 128x128 pages in the 4-bit format

  localparam int MAX_SIZE_LOG2_DEF = 10;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd2;

  localparam logic [LOG_W-1:0] WIDTH_LOG2_RESET  = 4'd7;
  localparam logic [LOG_W-1:0] HEIGHT_LOG2_RESET = 4'd7;

  typedef enum logic {
    FMT_IDX8 = 1'b0,
    FMT_IDX4 = 1'b1
  } pix_fmt_t;

  // Stage 1 -> stage 2 control and coordinate bits
  typedef struct packed {
    pix_fmt_t               fmt;
    logic [LOG_W-1:0]       shift;       // row pitch exponent used by the format
    logic [LOG_W-1:0]       vpl;         // log2 of vertical page count
    logic [SUM_LOG_W-1:0]   limit_log2;  // log2 of width * height
    logic                   nibble_high;
    logic [2:0]             ypos;        // row position inside a block
    logic [2:0]             xs;          // interleaved column
    logic [COORD_W-1:0]     x;
    logic [COORD_W-1:0]     y;
  } dec_t;

  // Stage 2 -> stage 3 control
  typedef struct packed {
    logic [SUM_LOG_W-1:0]   limit_log2;
    logic                   nibble_high;
  } merge_ctl_t;

endpackage

@@ hw/rtl/ptua_decode.sv @@
// ----------------------------------------------------------------------------
// ptua_decode
// Stage 1: clamp size exponents, split the coordinate and form the page number.
// ----------------------------------------------------------------------------
module ptua_decode #(
  parameter int MAX_SIZE_LOG2 = ptua_pkg::MAX_SIZE_LOG2_DEF,
  localparam int HPL_MAX = (MAX_SIZE_LOG2 > ptua_pkg::PAGE_LOG2) ?
                           (MAX_SIZE_LOG2 - ptua_pkg::PAGE_LOG2) : 0,
  localparam int PAGE_W  = HPL_MAX + 4
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [ptua_pkg::COORD_W-1:0]       pixel_x,
  input  logic [ptua_pkg::COORD_W-1:0]       pixel_y,
  input  logic [ptua_pkg::LOG_W-1:0]         width_log2,
  input  logic [ptua_pkg::LOG_W-1:0]         height_log2,
  input  ptua_pkg::pix_fmt_t                 pixel_format,
  output ptua_pkg::dec_t                     dec_q,
  output logic [PAGE_W-1:0]                  page_q
);
  import ptua_pkg::*;

  localparam logic [LOG_W-1:0] MAX_L  = LOG_W'(MAX_SIZE_LOG2);
  localparam logic [LOG_W-1:0] PAGE_L = LOG_W'(PAGE_LOG2);

  logic [LOG_W-1:0]  wl, hl, hpl, vpl;
  logic [2:0]        swap_sum;
  dec_t              dec_next;
  logic [PAGE_W-1:0] page_next;

  always_comb begin
    wl  = (width_log2  > MAX_L) ? MAX_L : width_log2;
    hl  = (height_log2 > MAX_L) ? MAX_L : height_log2;
    hpl = (wl > PAGE_L) ? (wl - PAGE_L) : '0;
    vpl = (hl > PAGE_L) ? (hl - PAGE_L) : '0;

    // columns swap by four on rows 2..5 of every eight
    swap_sum = pixel_y[2:0] + 3'd2;

    dec_next.fmt         = pixel_format;
    dec_next.shift       = (pixel_format == FMT_IDX8) ? wl : hl;
    dec_next.vpl         = vpl;
    dec_next.limit_log2  = SUM_LOG_W'(wl) + SUM_LOG_W'(hl);
    dec_next.nibble_high = (pixel_format == FMT_IDX4) && pixel_y[1];
    dec_next.ypos        = {pixel_y[3], pixel_y[2], pixel_y[0]};
    dec_next.xs          = pixel_x[2:0] + {swap_sum[2], 2'b00};
    dec_next.x           = pixel_x;
    dec_next.y           = pixel_y;

    page_next = (PAGE_W'(pixel_y[9:7]) << hpl) + PAGE_W'(pixel_x[9:7]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_q  <= dec_next;
      page_q <= page_next;
    end
  end

endmodule

@@ hw/rtl/ptua_shift.sv @@
// ----------------------------------------------------------------------------
// ptua_shift
// Stage 2: build the pitch-scaled and unscaled address terms, shift by pitch.
// ----------------------------------------------------------------------------
module ptua_shift #(
  parameter int MAX_SIZE_LOG2 = ptua_pkg::MAX_SIZE_LOG2_DEF,
  localparam int HPL_MAX = (MAX_SIZE_LOG2 > ptua_pkg::PAGE_LOG2) ?
                           (MAX_SIZE_LOG2 - ptua_pkg::PAGE_LOG2) : 0,
  localparam int PAGE_W  = HPL_MAX + 4,
  localparam int ADDR_W  = 2 * MAX_SIZE_LOG2 + 12
) (
  input  logic                   clk,
  input  logic                   en,
  input  ptua_pkg::dec_t         dec,
  input  logic [PAGE_W-1:0]      page,
  output ptua_pkg::merge_ctl_t   ctl_q,
  output logic [ADDR_W-1:0]      scaled_q,
  output logic [ADDR_W-1:0]      low_q
);
  import ptua_pkg::*;

  logic [PAGE_W-1:0] page_row, page_col;
  logic [ADDR_W-1:0] high_term, scaled_next, low_next;
  merge_ctl_t        ctl_next;

  always_comb begin
    page_row = page >> dec.vpl;
    page_col = page & ((PAGE_W'(1) << dec.vpl) - PAGE_W'(1));

    // address = (high_term << pitch) + low_term, fields packed without overlap
    if (dec.fmt == FMT_IDX8) begin
      high_term = ADDR_W'({dec.y[9:4], dec.ypos, 1'b0});
      low_next  = ADDR_W'({dec.x[9:4], dec.xs, dec.x[3], dec.y[1]});
    end else begin
      high_term = ADDR_W'({page_row, dec.x[6:5], dec.ypos, 1'b0});
      low_next  = ADDR_W'({page_col, dec.y[6:4], dec.xs, dec.x[4:3]});
    end
    scaled_next = high_term << dec.shift;

    ctl_next.limit_log2  = dec.limit_log2;
    ctl_next.nibble_high = dec.nibble_high;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_q    <= ctl_next;
      scaled_q <= scaled_next;
      low_q    <= low_next;
    end
  end

endmodule

@@ hw/rtl/ptua_merge.sv @@
// ----------------------------------------------------------------------------
// ptua_merge
// Stage 3: add the address terms, check the range and register the result.
// ----------------------------------------------------------------------------
module ptua_merge #(
  parameter int MAX_SIZE_LOG2 = ptua_pkg::MAX_SIZE_LOG2_DEF,
  localparam int ADDR_W = 2 * MAX_SIZE_LOG2 + 12
) (
  input  logic                               clk,
  input  logic                               en,
  input  ptua_pkg::merge_ctl_t               ctl,
  input  logic [ADDR_W-1:0]                  scaled,
  input  logic [ADDR_W-1:0]                  low,
  output logic [ptua_pkg::BYTE_ADDR_W-1:0]   byte_address,
  output logic                               nibble_high,
  output logic                               out_of_range
);
  import ptua_pkg::*;

  logic [ADDR_W-1:0] addr;

  assign addr = scaled + low;

  always_ff @(posedge clk) begin
    if (en) begin
      byte_address <= addr[BYTE_ADDR_W-1:0];
      nibble_high  <= ctl.nibble_high;
      out_of_range <= (addr >> ctl.limit_log2) != '0;
    end
  end

endmodule

@@ hw/rtl/palettized_texture_unswizzle_address.sv @@
// ----------------------------------------------------------------------------
// palettized_texture_unswizzle_address
// Maps a linear pixel coordinate to its byte address and nibble in a
// swizzled 8-bit or 4-bit palettized texture.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries pixel_x, pixel_y. Output
//   channel (out_valid / out_stall) carries byte_address, nibble_high and
//   out_of_range. A transaction completes on a clock edge with valid high
//   and stall low.
//   Configuration: pulse cfg_write with cfg_index / cfg_data while the pipe
//   is empty (0 = width_log2, 1 = height_log2, 2 = pixel_format).
//   Pipeline: three register stages (decode, shift, merge); the decode stage
//   loads on the input transaction edge, then the shift and merge stages
//   load in turn, and out_valid rises when the merge stage loads.
//   Throughput: one transaction per cycle while the output is not stalled,
//   with each stage taking new data as the stage after it moves on.
//   Stall: each stage holds only while the stage behind it is full and
//   stalled, so bubbles collapse; in_stall rises only when all three stages
//   hold data and out_stall is high.
//   Reset: rst clears all stage valid bits and loads width_log2 = 7,
//   height_log2 = 7, pixel_format = 8-bit.
// ----------------------------------------------------------------------------
module palettized_texture_unswizzle_address #(
  parameter int MAX_SIZE_LOG2 = ptua_pkg::MAX_SIZE_LOG2_DEF,
  localparam int HPL_MAX = (MAX_SIZE_LOG2 > ptua_pkg::PAGE_LOG2) ?
                           (MAX_SIZE_LOG2 - ptua_pkg::PAGE_LOG2) : 0,
  localparam int PAGE_W  = HPL_MAX + 4,
  localparam int ADDR_W  = 2 * MAX_SIZE_LOG2 + 12
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_write,
  input  logic [ptua_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptua_pkg::CFG_W-1:0]         cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ptua_pkg::COORD_W-1:0]       pixel_x,
  input  logic [ptua_pkg::COORD_W-1:0]       pixel_y,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ptua_pkg::BYTE_ADDR_W-1:0]   byte_address,
  output logic                               nibble_high,
  output logic                               out_of_range
);
  import ptua_pkg::*;

  // configuration registers
  logic [LOG_W-1:0] width_log2;
  logic [LOG_W-1:0] height_log2;
  pix_fmt_t         pixel_format;

  // stage valid bits; stage 3 valid is out_valid
  logic v1, v2;
  logic en1, en2, en3;

  dec_t              dec;
  logic [PAGE_W-1:0] page;
  merge_ctl_t        ctl;
  logic [ADDR_W-1:0] scaled, low;

  // Write configuration; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2   <= WIDTH_LOG2_RESET;
      height_log2  <= HEIGHT_LOG2_RESET;
      pixel_format <= FMT_IDX8;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH_LOG2:   width_log2   <= cfg_data[LOG_W-1:0];
        REG_HEIGHT_LOG2:  height_log2  <= cfg_data[LOG_W-1:0];
        REG_PIXEL_FORMAT: pixel_format <= pix_fmt_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  // Advance a stage when the one after it is empty or moving on.
  assign en3      = !out_valid || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1        <= in_valid;
      if (en2) v2        <= v1;
      if (en3) out_valid <= v2;
    end
  end

  ptua_decode #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2)) u_decode (
    .clk          (clk),
    .en           (en1 && in_valid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .width_log2   (width_log2),
    .height_log2  (height_log2),
    .pixel_format (pixel_format),
    .dec_q        (dec),
    .page_q       (page)
  );

  ptua_shift #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2)) u_shift (
    .clk      (clk),
    .en       (en2 && v1),
    .dec      (dec),
    .page     (page),
    .ctl_q    (ctl),
    .scaled_q (scaled),
    .low_q    (low)
  );

  ptua_merge #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2)) u_merge (
    .clk          (clk),
    .en           (en3 && v2),
    .ctl          (ctl),
    .scaled       (scaled),
    .low          (low),
    .byte_address (byte_address),
    .nibble_high  (nibble_high),
    .out_of_range (out_of_range)
  );

  // Hold input only when the whole pipe is full and the output stalls.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && out_valid && out_stall))
    else $error("in_stall raised with room in the pipe");

  // An accepted transaction occupies stage 1 on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted transaction lost at stage 1");

  // Draining the output with stage 2 empty leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !v2) |=> !out_valid)
    else $error("result repeated after drain");

endmodule

@@ sim/palettized_texture_unswizzle_address_test.sv @@
// ----------------------------------------------------------------------------
// palettized_texture_unswizzle_address_test
// Drives pixel coordinates through the unswizzle address block under many
// size and format settings. Each result is checked against a local predictor.
// Both channels get random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module palettized_texture_unswizzle_address_test;
  import ptua_pkg::*;

  // Index 3 has no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int PIPE_DEPTH    = 3;   // decode, shift, merge
  localparam int SIZE_LOG2_CAP = 10;
  localparam int BATCHES       = 31;
  localparam int BATCH_LEN     = 50;

  typedef struct {
    bit [COORD_W-1:0] x;
    bit [COORD_W-1:0] y;
  } coord_t;

  typedef struct {
    bit [BYTE_ADDR_W-1:0] addr;
    bit                   nib;
    bit                   oor;
  } texel_loc_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_WIDTH_LOG2;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [COORD_W-1:0]     pixel_x = '0;
  logic [COORD_W-1:0]     pixel_y = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [BYTE_ADDR_W-1:0] byte_address;
  logic                   nibble_high;
  logic                   out_of_range;

  // Register shadow, updated only while the pipe is empty.
  logic [LOG_W-1:0] cur_width_log2  = WIDTH_LOG2_RESET;
  logic [LOG_W-1:0] cur_height_log2 = HEIGHT_LOG2_RESET;
  pix_fmt_t         cur_fmt         = FMT_IDX8;

  coord_t     coords_to_send[$];
  texel_loc_t expected_locs[$];

  int send_gap_pct = 0;
  int out_hold_pct = 0;
  int mismatches   = 0;
  int coords_sent  = 0;
  int results_seen = 0;
  int settings_used = 1;
  int oor_seen     = 0;

  palettized_texture_unswizzle_address dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_address (byte_address),
    .nibble_high  (nibble_high),
    .out_of_range (out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bail out if the pipe hangs; a slow correct run ends far sooner.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Saturate a size exponent at the largest supported texture.
  function automatic int size_exp(input logic [LOG_W-1:0] v);
    return (v > SIZE_LOG2_CAP) ? SIZE_LOG2_CAP : int'(v);
  endfunction

  // Row-in-block position and interleaved column, common to both formats.
  function automatic longint unsigned column_offset(input longint unsigned x, y,
                                                    input int pitch_log2);
    longint unsigned swap, ypos;
    swap = (((y + 2) >> 2) & 1) != 0 ? 4 : 0;
    ypos = (((y & ~64'h3) >> 1) + (y & 1)) & 7;
    return ((ypos << pitch_log2) << 1) + (((x + swap) & 7) << 2);
  endfunction

  // Work out where the palette index of (x, y) lives in the swizzled buffer.
  function automatic texel_loc_t swizzle_lookup(input bit [COORD_W-1:0] px, py);
    texel_loc_t      loc;
    longint unsigned x, y, addr, blk, sel, page, prow, pcol, page_loc, xl, yl;
    int              wl, hl, hpl, vpl;
    x   = 64'(px);
    y   = 64'(py);
    wl  = size_exp(cur_width_log2);
    hl  = size_exp(cur_height_log2);
    loc.nib = 1'b0;
    if (cur_fmt == FMT_IDX8) begin
      blk  = ((y & ~64'hF) << wl) + ((x & ~64'hF) << 1);
      sel  = ((y >> 1) & 1) + ((x >> 2) & 2);
      addr = blk + column_offset(x, y, wl) + sel;
    end else begin
      hpl      = (wl > PAGE_LOG2) ? wl - PAGE_LOG2 : 0;
      vpl      = (hl > PAGE_LOG2) ? hl - PAGE_LOG2 : 0;
      page     = ((y >> 7) << hpl) + (x >> 7);
      prow     = (page >> vpl) * 32;
      pcol     = (page & ((64'd1 << vpl) - 1)) * 64;
      page_loc = ((prow << hl) << 1) + (pcol << 2);
      xl       = x & 64'h7F;
      yl       = y & 64'h7F;
      blk      = (((xl & ~64'h1F) >> 1) << hl) + ((yl & ~64'hF) << 1);
      sel      = (x >> 3) & 3;
      addr     = page_loc + blk + column_offset(x, y, hl) + sel;
      loc.nib  = y[1];
    end
    loc.addr = addr[BYTE_ADDR_W-1:0];
    loc.oor  = (addr >= (64'd1 << (wl + hl)));
    return loc;
  endfunction

  // Coordinate driver: advance only when the current transaction is taken.
  always @(posedge clk) begin : coord_driver
    coord_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_locs.push_back(swizzle_lookup(pixel_x, pixel_y));
        coords_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (coords_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = coords_to_send.pop_front();
          pixel_x  <= nxt.x;
          pixel_y  <= nxt.y;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Random backpressure on the result side.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < out_hold_pct);
    end
  end

  task automatic flag_result(input string msg);
    if (mismatches < 10) $display("[%0t] %s", $realtime, msg);
    mismatches++;
  endtask

  // Result checker: compare each field against the oldest prediction.
  always @(posedge clk) begin : result_check
    texel_loc_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_locs.size() == 0) begin
        flag_result($sformatf("unexpected result addr=%h nib=%b oor=%b",
                              byte_address, nibble_high, out_of_range));
      end else begin
        want = expected_locs.pop_front();
        if (want.oor) oor_seen++;
        if (byte_address !== want.addr || nibble_high !== want.nib ||
            out_of_range !== want.oor) begin
          flag_result($sformatf({"result mismatch: addr exp %h got %h, ",
                                 "nibble exp %b got %b, range exp %b got %b"},
                                want.addr, byte_address, want.nib, nibble_high,
                                want.oor, out_of_range));
        end
      end
    end
  end

  task automatic queue_coord(input int x, y);
    coord_t c;
    c.x = COORD_W'(x);
    c.y = COORD_W'(y);
    coords_to_send.push_back(c);
  endtask

  // Hold until every queued coordinate went in and every result came out,
  // then let the pipe drain a little more.
  task automatic wait_idle();
    do @(negedge clk);
    while (coords_to_send.size() != 0 || in_valid || expected_locs.size() != 0);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  // Write all registers back to back, plus a throwaway write to the spare
  // index. The format write carries junk in its upper bits on purpose.
  task automatic apply_setting(input logic [LOG_W-1:0] w, h, input pix_fmt_t fmt);
    logic [CFG_W-1:0] fmt_word;
    fmt_word = {3'($urandom_range(7)), fmt};
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_WIDTH_LOG2;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT_LOG2;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_PIXEL_FORMAT;
    cfg_data  <= fmt_word;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_width_log2  = w;
    cur_height_log2 = h;
    cur_fmt         = pix_fmt_t'(fmt_word[0]);
    settings_used++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [LOG_W-1:0] ext_w[6] = '{4'd0, 4'd15, 4'd10, 4'd0, 4'd15, 4'd11};
    logic [LOG_W-1:0] ext_h[6] = '{4'd0, 4'd15, 4'd10, 4'd15, 4'd0, 4'd3};
    pix_fmt_t         ext_f[6] = '{FMT_IDX8, FMT_IDX8, FMT_IDX4, FMT_IDX4,
                                   FMT_IDX8, FMT_IDX4};
    logic [LOG_W-1:0] w, h;
    pix_fmt_t         f;
    int               wmask, hmask;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_gap_pct = 26;
    out_hold_pct = 81;

    // Reset setting, 128x128 8-bit: corners, block edges, off-texture points.
    queue_coord(0, 0);
    queue_coord(127, 127);
    queue_coord(128, 0);
    queue_coord(0, 128);
    queue_coord(1023, 1023);
    queue_coord(1023, 0);
    queue_coord(0, 1023);
    queue_coord(5, 6);
    wait_idle();

    // Oversized exponents saturate; 4-bit pages and both nibbles.
    apply_setting(4'd15, 4'd15, FMT_IDX4);
    queue_coord(0, 0);
    queue_coord(1023, 1023);
    queue_coord(127, 127);
    queue_coord(128, 128);
    queue_coord(1023, 0);
    queue_coord(0, 1023);
    queue_coord(10, 3);
    wait_idle();

    // A 1x1 texture: nearly everything lands out of range.
    apply_setting(4'd0, 4'd0, FMT_IDX4);
    queue_coord(0, 0);
    queue_coord(1, 1);
    queue_coord(1023, 1023);
    wait_idle();

    apply_setting(4'd10, 4'd0, FMT_IDX8);
    queue_coord(0, 0);
    queue_coord(1023, 0);
    queue_coord(1023, 1023);
    wait_idle();

    // Random batches, each under its own setting. The sender stays paused
    // between batches until the last result is back.
    for (int b = 0; b < BATCHES; b++) begin
      if (b < 10) begin
        send_gap_pct = 26;
        out_hold_pct = 81;
      end else if (b < 20) begin
        send_gap_pct = 81;
        out_hold_pct = 26;
      end else begin
        send_gap_pct = 0;
        out_hold_pct = 0;
      end
      if (b < 6) begin
        w = ext_w[b];
        h = ext_h[b];
        f = ext_f[b];
      end else begin
        w = LOG_W'($urandom_range(15));
        h = LOG_W'($urandom_range(15));
        f = pix_fmt_t'($urandom_range(1));
      end
      apply_setting(w, h, f);
      wmask = (1 << size_exp(w)) - 1;
      hmask = (1 << size_exp(h)) - 1;
      // Mostly on-texture coordinates, the rest anywhere in the field.
      for (int i = 0; i < BATCH_LEN; i++) begin
        if ($urandom_range(99) < 65)
          queue_coord($urandom_range(wmask), $urandom_range(hmask));
        else
          queue_coord($urandom_range(1023), $urandom_range(1023));
      end
      wait_idle();
    end

    $display("covered %0d coordinates over %0d register settings, both formats,",
             coords_sent, settings_used);
    $display("  size exponents 0..15 with %0d out-of-range results",
             oor_seen);
    mismatches += expected_locs.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
